FILE: src/r2h_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package r2h_pkg;

	// Default channel width and the fixed hue width (fraction of a turn).
	localparam int CHANNEL_BITS_DEF = 16;
	localparam int HUE_BITS         = 16;

	// Sector base of the hue, in sixths of a turn.
	typedef enum logic [2:0] {
		BASE_RED   = 3'd0,
		BASE_GREEN = 3'd2,
		BASE_BLUE  = 3'd4,
		BASE_WRAP  = 3'd6
	} hue_base_t;

	// Control that travels down the pipeline with each request.
	typedef struct packed {
		logic valid;
		logic gray;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: src/r2h_front.sv
// Front end: sector select (s1) and divider set-up (s2).
`default_nettype none

module r2h_front import r2h_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      pixel_valid,
	input  logic [CHANNEL_BITS-1:0]   red,
	input  logic [CHANNEL_BITS-1:0]   green,
	input  logic [CHANNEL_BITS-1:0]   blue,
	output pipe_ctrl_t                ctrl_s2,
	output logic [CHANNEL_BITS+2:0]   hnum_s2,
	output logic [CHANNEL_BITS+2:0]   hden_s2,
	output logic [CHANNEL_BITS-1:0]   rrem_s2,
	output logic [CHANNEL_BITS-1:0]   rlow_s2,
	output logic [CHANNEL_BITS-1:0]   rden_s2
);

	localparam int HW = CHANNEL_BITS + 3;

	hue_base_t                 base_c;
	logic                      add_c;
	logic [CHANNEL_BITS-1:0]   part_c;
	logic [CHANNEL_BITS-1:0]   span_c;
	logic [CHANNEL_BITS-1:0]   lo_c;
	logic [CHANNEL_BITS-1:0]   hi_c;

	pipe_ctrl_t                ctrl_s1;
	hue_base_t                 base_s1;
	logic                      add_s1;
	logic [CHANNEL_BITS-1:0]   part_s1;
	logic [CHANNEL_BITS-1:0]   span_s1;
	logic [CHANNEL_BITS-1:0]   lo_s1;
	logic [CHANNEL_BITS-1:0]   hi_s1;

	logic [HW-1:0]             bspan_c;

	// Sector of the largest channel; ties follow a fixed compare order.
	// Gray pixels fall through to the red sector and are flagged.
	always_comb begin
		base_c = BASE_RED;
		add_c  = 1'b1;
		part_c = green - blue;
		span_c = red - blue;
		lo_c   = blue;
		hi_c   = red;
		if (red < green) begin
			if (red < blue) begin
				if (green < blue) begin
					base_c = BASE_BLUE;
					add_c  = 1'b0;
					part_c = green - red;
					span_c = blue - red;
					lo_c   = red;
					hi_c   = blue;
				end else begin
					base_c = BASE_GREEN;
					add_c  = 1'b1;
					part_c = blue - red;
					span_c = green - red;
					lo_c   = red;
					hi_c   = green;
				end
			end else begin
				base_c = BASE_GREEN;
				add_c  = 1'b0;
				part_c = red - blue;
				span_c = green - blue;
				lo_c   = blue;
				hi_c   = green;
			end
		end else if (red < blue) begin
			base_c = BASE_BLUE;
			add_c  = 1'b1;
			part_c = red - green;
			span_c = blue - green;
			lo_c   = green;
			hi_c   = blue;
		end else if (green < blue) begin
			base_c = BASE_WRAP;
			add_c  = 1'b0;
			part_c = blue - green;
			span_c = red - green;
			lo_c   = green;
			hi_c   = red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= pixel_valid;
			ctrl_s1.gray  <= (red == green) && (green == blue);
			ctrl_s2       <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= base_c;
			add_s1  <= add_c;
			part_s1 <= part_c;
			span_s1 <= span_c;
			lo_s1   <= lo_c;
			hi_s1   <= hi_c;
		end
	end

	// Hue numerator base*span +/- part, always below 6*span except for gray pixels.
	assign bspan_c = HW'(span_s1) * HW'(base_s1);

	// Ratio numerator lo*(2^W-1) split as (lo-1)*2^W + (2^W-lo).
	always_ff @(posedge clk) begin
		if (en) begin
			hnum_s2 <= add_s1 ? (bspan_c + HW'(part_s1)) : (bspan_c - HW'(part_s1));
			hden_s2 <= (HW'(span_s1) << 2) + (HW'(span_s1) << 1);
			rrem_s2 <= lo_s1 - CHANNEL_BITS'(lo_s1 != '0);
			rlow_s2 <= '0 - lo_s1;
			rden_s2 <= hi_s1;
		end
	end

endmodule

`default_nettype wire

FILE: src/r2h_div_step.sv
// One restoring division step for the hue and the min/max ratio.
`default_nettype none

module r2h_div_step import r2h_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	parameter int STEP         = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  pipe_ctrl_t                src_ctrl,
	input  logic [CHANNEL_BITS+2:0]   src_hrem,
	input  logic [CHANNEL_BITS+2:0]   src_hden,
	input  logic [HUE_BITS-1:0]       src_hq,
	input  logic [CHANNEL_BITS-1:0]   src_rrem,
	input  logic [CHANNEL_BITS-1:0]   src_rlow,
	input  logic [CHANNEL_BITS-1:0]   src_rden,
	input  logic [CHANNEL_BITS-1:0]   src_rq,
	output pipe_ctrl_t                ctrl_s,
	output logic [CHANNEL_BITS+2:0]   hrem_s,
	output logic [CHANNEL_BITS+2:0]   hden_s,
	output logic [HUE_BITS-1:0]       hq_s,
	output logic [CHANNEL_BITS-1:0]   rrem_s,
	output logic [CHANNEL_BITS-1:0]   rlow_s,
	output logic [CHANNEL_BITS-1:0]   rden_s,
	output logic [CHANNEL_BITS-1:0]   rq_s
);

	localparam int HW     = CHANNEL_BITS + 3;
	localparam bit HUE_ON = (STEP < HUE_BITS);
	localparam bit RAT_ON = (STEP < CHANNEL_BITS);

	logic [HW:0]               hsh;
	logic                      hge;
	logic [HW-1:0]             hrem_n;
	logic [HUE_BITS-1:0]       hq_n;
	logic [CHANNEL_BITS:0]     rsh;
	logic                      rge;
	logic [CHANNEL_BITS-1:0]   rrem_n;
	logic [CHANNEL_BITS-1:0]   rlow_n;
	logic [CHANNEL_BITS-1:0]   rq_n;

	always_comb begin
		// hue: remainder doubles each step, numerator bits beyond it are zero
		hsh = {src_hrem, 1'b0};
		hge = hsh >= {1'b0, src_hden};
		if (HUE_ON) begin
			hrem_n = hge ? HW'(hsh - {1'b0, src_hden}) : hsh[HW-1:0];
			hq_n   = {src_hq[HUE_BITS-2:0], hge};
		end else begin
			hrem_n = src_hrem;
			hq_n   = src_hq;
		end

		// ratio: next numerator bit shifts in from the low word
		rsh = {src_rrem, src_rlow[CHANNEL_BITS-1]};
		rge = rsh >= {1'b0, src_rden};
		if (RAT_ON) begin
			rrem_n = rge ? CHANNEL_BITS'(rsh - {1'b0, src_rden}) : rsh[CHANNEL_BITS-1:0];
			rlow_n = src_rlow << 1;
			rq_n   = {src_rq[CHANNEL_BITS-2:0], rge};
		end else begin
			rrem_n = src_rrem;
			rlow_n = src_rlow;
			rq_n   = src_rq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s <= '0;
		end else if (en) begin
			ctrl_s <= src_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hrem_s <= hrem_n;
			hden_s <= src_hden;
			hq_s   <= hq_n;
			rrem_s <= rrem_n;
			rlow_s <= rlow_n;
			rden_s <= src_rden;
			rq_s   <= rq_n;
		end
	end

endmodule

`default_nettype wire

FILE: src/r2h_out_skid.sv
// Output register with a one-entry skid buffer.
`default_nettype none

module r2h_out_skid import r2h_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [HUE_BITS-1:0]       push_hue,
	input  logic [CHANNEL_BITS-1:0]   push_ratio,
	input  logic [CHANNEL_BITS-1:0]   push_value,
	input  logic                      hsv_ready,
	output logic                      hsv_valid,
	output logic [HUE_BITS-1:0]       hue,
	output logic [CHANNEL_BITS-1:0]   min_over_max,
	output logic [CHANNEL_BITS-1:0]   value,
	output logic                      full
);

	logic                      out_valid_q;
	logic [HUE_BITS-1:0]       out_hue_q;
	logic [CHANNEL_BITS-1:0]   out_ratio_q;
	logic [CHANNEL_BITS-1:0]   out_value_q;
	logic                      skid_valid_q;
	logic [HUE_BITS-1:0]       skid_hue_q;
	logic [CHANNEL_BITS-1:0]   skid_ratio_q;
	logic [CHANNEL_BITS-1:0]   skid_value_q;
	logic                      take;

	// Output slot frees when empty or being taken.
	assign take = !out_valid_q || hsv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// No push can arrive while the skid is full: the pipe is held then.
	always_ff @(posedge clk) begin
		if (take) begin
			out_hue_q   <= skid_valid_q ? skid_hue_q   : push_hue;
			out_ratio_q <= skid_valid_q ? skid_ratio_q : push_ratio;
			out_value_q <= skid_valid_q ? skid_value_q : push_value;
		end else if (push) begin
			skid_hue_q   <= push_hue;
			skid_ratio_q <= push_ratio;
			skid_value_q <= push_value;
		end
	end

	assign hsv_valid    = out_valid_q;
	assign hue          = out_hue_q;
	assign min_over_max = out_ratio_q;
	assign value        = out_value_q;
	assign full         = skid_valid_q;

endmodule

`default_nettype wire

FILE: src/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter: front end, divider pipeline, output buffer.
// A request passes the s1 and s2 registers, every divider stage register and the output register.
// Throughput: one request per cycle unless halted; one quotient bit per divider per stage.
// A stalled result holds the pipe once the one-entry skid buffer fills.
// Reset (arst_n low) clears all valid bits and both output slots; data is not reset.
`default_nettype none

module rgb_to_hsv_converter_core import r2h_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  logic [CHANNEL_BITS-1:0]   red,
	input  logic [CHANNEL_BITS-1:0]   green,
	input  logic [CHANNEL_BITS-1:0]   blue,
	output logic                      hsv_valid,
	input  logic                      hsv_ready,
	output logic [HUE_BITS-1:0]       hue,
	output logic [CHANNEL_BITS-1:0]   min_over_max,
	output logic [CHANNEL_BITS-1:0]   value
);

	// Divider stage count: enough for the longer of the two quotients.
	localparam int NSTEP = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;
	localparam int HW    = CHANNEL_BITS + 3;

	logic                      en;
	logic                      skid_full;
	logic                      push;
	logic [HUE_BITS-1:0]       push_hue;
	logic [CHANNEL_BITS-1:0]   push_ratio;

	// Stage k of the divider chain; entry 0 is the front end's s2 output.
	pipe_ctrl_t                ctrl_s [0:NSTEP];
	logic [HW-1:0]             hrem_s [0:NSTEP];
	logic [HW-1:0]             hden_s [0:NSTEP];
	logic [HUE_BITS-1:0]       hq_s   [0:NSTEP];
	logic [CHANNEL_BITS-1:0]   rrem_s [0:NSTEP];
	logic [CHANNEL_BITS-1:0]   rlow_s [0:NSTEP];
	logic [CHANNEL_BITS-1:0]   rden_s [0:NSTEP];
	logic [CHANNEL_BITS-1:0]   rq_s   [0:NSTEP];

	// The whole pipe moves together; it only halts while the skid entry is full.
	// Since that flag is a register, pixel_ready has no path from hsv_ready.
	assign en          = !skid_full;
	assign pixel_ready = en;

	// Sector select and divider set-up (two stages).
	r2h_front #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.pixel_valid (pixel_valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.ctrl_s2     (ctrl_s[0]),
		.hnum_s2     (hrem_s[0]),
		.hden_s2     (hden_s[0]),
		.rrem_s2     (rrem_s[0]),
		.rlow_s2     (rlow_s[0]),
		.rden_s2     (rden_s[0])
	);

	// Quotients start empty and fill from the bottom, one bit per stage until full.
	assign hq_s[0] = '0;
	assign rq_s[0] = '0;

	// Two restoring dividers run side by side: hue = num*2^16 / (6*span),
	// ratio = lo*(2^W-1) / hi. Each stage does one step of each divider whose quotient is not yet complete.
	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		r2h_div_step #(
			.CHANNEL_BITS (CHANNEL_BITS),
			.STEP         (k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.src_ctrl (ctrl_s[k]),
			.src_hrem (hrem_s[k]),
			.src_hden (hden_s[k]),
			.src_hq   (hq_s[k]),
			.src_rrem (rrem_s[k]),
			.src_rlow (rlow_s[k]),
			.src_rden (rden_s[k]),
			.src_rq   (rq_s[k]),
			.ctrl_s   (ctrl_s[k+1]),
			.hrem_s   (hrem_s[k+1]),
			.hden_s   (hden_s[k+1]),
			.hq_s     (hq_s[k+1]),
			.rrem_s   (rrem_s[k+1]),
			.rlow_s   (rlow_s[k+1]),
			.rden_s   (rden_s[k+1]),
			.rq_s     (rq_s[k+1])
		);
	end

	// Gray pixels (black too) give hue 0 and a full-scale ratio; the divider
	// output is meaningless for them. The divisor of the ratio is the value.
	assign push       = en && ctrl_s[NSTEP].valid;
	assign push_hue   = ctrl_s[NSTEP].gray ? '0 : hq_s[NSTEP];
	assign push_ratio = ctrl_s[NSTEP].gray ? '1 : rq_s[NSTEP];

	r2h_out_skid #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_hue     (push_hue),
		.push_ratio   (push_ratio),
		.push_value   (rden_s[NSTEP]),
		.hsv_ready    (hsv_ready),
		.hsv_valid    (hsv_valid),
		.hue          (hue),
		.min_over_max (min_over_max),
		.value        (value),
		.full         (skid_full)
	);

endmodule

`default_nettype wire

FILE: src/r2h_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
`default_nettype none

module r2h_checker #(
	parameter int CHANNEL_BITS = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      pixel_ready,
	input logic                      hsv_valid,
	input logic                      hsv_ready,
	input logic [15:0]               hue,
	input logic [CHANNEL_BITS-1:0]   min_over_max,
	input logic [CHANNEL_BITS-1:0]   value
);

	localparam logic [CHANNEL_BITS-1:0] FULL = '1;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) &&
			$stable(min_over_max) && $stable(value))
		else $error("result changed while stalled");

	// Input back-pressure only while a result is waiting.
	a_ready_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> hsv_valid)
		else $error("input held off with no result pending");

	// Taking a result frees the input side on the next cycle.
	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready && hsv_ready |=> pixel_ready)
		else $error("input still held after result taken");

	// Full-scale ratio only for gray pixels, which have hue 0.
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && min_over_max == FULL |-> hue == 16'd0)
		else $error("full ratio with non-zero hue");

	// Black is gray.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && value == '0 |-> min_over_max == FULL && hue == 16'd0)
		else $error("black pixel gave wrong hue or ratio");

endmodule

bind rgb_to_hsv_converter_core r2h_checker #(
	.CHANNEL_BITS (CHANNEL_BITS)
) u_r2h_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_ready  (pixel_ready),
	.hsv_valid    (hsv_valid),
	.hsv_ready    (hsv_ready),
	.hue          (hue),
	.min_over_max (min_over_max),
	.value        (value)
);

`default_nettype wire
